### sv/nmea_dfr_pkg.sv
// ----------------------------------------------------------------------------
// nmea_dfr_pkg
// shared types, character codes and hex decoding for the sentence deframer
// ----------------------------------------------------------------------------
package nmea_dfr_pkg;

	typedef enum logic [2:0] {
		K_DATA    = 3'd0,
		K_OK      = 3'd1,
		K_CHKERR  = 3'd2,
		K_TIMEOUT = 3'd3,
		K_OVERLEN = 3'd4
	} kind_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] data_byte;
		logic [7:0] frame_length;
		logic [7:0] received_sum;
		logic [7:0] computed_sum;
	} res_t;

	localparam logic [7:0]  CH_DOLLAR     = 8'h24;
	localparam logic [7:0]  CH_STAR       = 8'h2A;
	localparam logic [7:0]  CH_ZERO       = 8'h30;
	localparam logic [7:0]  CH_NINE       = 8'h39;
	localparam logic [7:0]  CH_LOW_A      = 8'h61;
	localparam logic [7:0]  CH_LOW_Z      = 8'h7A;
	localparam logic [7:0]  CASE_OFS      = 8'h20;
	localparam logic [7:0]  HEX_ALPHA_OFS = 8'd55;
	localparam logic [31:0] TIMEOUT_RESET = 32'd1000;
	localparam logic [8:0]  BUFFER_BYTES  = 9'd128;

	function automatic logic [7:0] hex_digit(input logic [7:0] ch);
		logic [7:0] u;
		u = ch;
		if (u >= CH_LOW_A && u <= CH_LOW_Z) begin
			u = u - CASE_OFS;
		end
		if (u > CH_NINE) begin
			hex_digit = u - HEX_ALPHA_OFS;
		end else begin
			hex_digit = u - CH_ZERO;
		end
	endfunction

endpackage

### sv/nmea_dfr_core.sv
// ----------------------------------------------------------------------------
// nmea_dfr_core
// sentence state machine: xor sum, length count, hex checksum compare
// ----------------------------------------------------------------------------
module nmea_dfr_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wen,
	input  logic [31:0]          cfg_wdata,
	input  logic                 step,
	input  logic [7:0]           char_in,
	input  logic [31:0]          gap_ticks,
	output logic                 res_valid,
	output nmea_dfr_pkg::res_t   res
);

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_PAYLOAD,
		PH_HEX1,
		PH_HEX2
	} phase_t;

	phase_t      phase_q, phase_d;
	logic [7:0]  sum_q, sum_d;
	logic [7:0]  cnt_q, cnt_d;
	logic [7:0]  hex1_q, hex1_d;
	logic [31:0] timeout_q;
	logic [7:0]  sum_x;
	logic [7:0]  rs;
	logic [8:0]  cnt_next;
	logic [8:0]  cnt_max;

	assign sum_x    = sum_q ^ char_in;
	assign cnt_next = {1'b0, cnt_q} + 9'd1;
	assign cnt_max  = nmea_dfr_pkg::BUFFER_BYTES - 9'd1;
	assign rs       = {nmea_dfr_pkg::hex_digit(hex1_q) << 4}
	                + nmea_dfr_pkg::hex_digit(char_in);

	always_comb begin
		phase_d   = phase_q;
		sum_d     = sum_q;
		cnt_d     = cnt_q;
		hex1_d    = hex1_q;
		res_valid = 1'b0;
		res       = '0;
		unique case (phase_q)
			PH_IDLE: begin
				if (char_in == nmea_dfr_pkg::CH_DOLLAR) begin
					sum_d            = '0;
					hex1_d           = '0;
					cnt_d            = 8'd1;
					phase_d          = PH_PAYLOAD;
					res_valid        = 1'b1;
					res.kind         = nmea_dfr_pkg::K_DATA;
					res.data_byte    = char_in;
					res.frame_length = 8'd1;
				end
			end
			PH_PAYLOAD: begin
				priority if (char_in == nmea_dfr_pkg::CH_STAR) begin
					phase_d = PH_HEX1;
				end else if (gap_ticks > timeout_q) begin
					phase_d          = PH_IDLE;
					res_valid        = 1'b1;
					res.kind         = nmea_dfr_pkg::K_TIMEOUT;
					res.frame_length = cnt_q;
					res.computed_sum = sum_q;
				end else if (cnt_next >= nmea_dfr_pkg::BUFFER_BYTES) begin
					sum_d            = sum_x;
					cnt_d            = cnt_max[7:0];
					phase_d          = PH_IDLE;
					res_valid        = 1'b1;
					res.kind         = nmea_dfr_pkg::K_OVERLEN;
					res.frame_length = cnt_max[7:0];
					res.computed_sum = sum_x;
				end else begin
					sum_d            = sum_x;
					cnt_d            = cnt_next[7:0];
					res_valid        = 1'b1;
					res.kind         = nmea_dfr_pkg::K_DATA;
					res.data_byte    = char_in;
					res.frame_length = cnt_next[7:0];
					res.computed_sum = sum_x;
				end
			end
			PH_HEX1: begin
				hex1_d  = char_in;
				phase_d = PH_HEX2;
			end
			PH_HEX2: begin
				phase_d          = PH_IDLE;
				res_valid        = 1'b1;
				res.kind         = (rs == sum_q) ? nmea_dfr_pkg::K_OK
				                                 : nmea_dfr_pkg::K_CHKERR;
				res.frame_length = cnt_q;
				res.received_sum = rs;
				res.computed_sum = sum_q;
			end
			default: begin
				phase_d = PH_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			sum_q     <= '0;
			cnt_q     <= '0;
			hex1_q    <= '0;
			timeout_q <= nmea_dfr_pkg::TIMEOUT_RESET;
		end else begin
			if (cfg_wen) begin
				timeout_q <= cfg_wdata;
			end
			if (step) begin
				phase_q <= phase_d;
				sum_q   <= sum_d;
				cnt_q   <= cnt_d;
				hex1_q  <= hex1_d;
			end
		end
	end

endmodule

### sv/nmea_sentence_deframer_top.sv
// ----------------------------------------------------------------------------
// nmea_sentence_deframer_top
// nmea 0183 sentence deframer with xor checksum check
// ----------------------------------------------------------------------------
// usage:
//   s_* carries one received character per item together with the ticks
//   since the previous character. characters before a dollar sign are
//   dropped. m_* gives one item per frame character (kind data) and one
//   status item per frame: ok, checksum error, timeout or overlength. the star and
//   the two hex checksum characters give no data item. cfg_wen/cfg_wdata write the
//   gap timeout in ticks, only while the block is idle: a user rule, not enforced.
// path and throughput:
//   an accepted character sits in the input register, is run through the
//   sentence state machine when the output register is free, and its result
//   lands in the output register, shown on m_*. while the output does not stall, one
//   character per cycle is taken, set by the single pass through the state machine.
// reset:
//   arst_n clears both valid flags and the state machine; timeout goes to 1000.
// stalls:
//   when m_tready is low the output register holds its item; the input
//   register still fills, and s_tready drops only when both are occupied.
// ----------------------------------------------------------------------------
module nmea_sentence_deframer_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wen,
	input  logic [31:0] cfg_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // char_in[7:0], gap_ticks[39:8]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // data_byte, frame_length, received_sum, computed_sum
	output logic [2:0]  m_tuser    // kind
);

	logic               valid_s1;
	logic [7:0]         char_s1;
	logic [31:0]        gap_s1;
	logic               valid_s2;
	nmea_dfr_pkg::res_t res_s2;
	logic               out_free;
	logic               step;
	logic               res_valid;
	nmea_dfr_pkg::res_t res;

	assign out_free = !valid_s2 || m_tready;
	assign step     = valid_s1 && out_free;
	assign s_tready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			char_s1 <= s_tdata[7:0];
			gap_s1  <= s_tdata[39:8];
		end
	end

	nmea_dfr_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata),
		.step      (step),
		.char_in   (char_s1),
		.gap_ticks (gap_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= step && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			res_s2 <= res;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {res_s2.computed_sum, res_s2.received_sum,
	                   res_s2.frame_length, res_s2.data_byte};
	assign m_tuser  = res_s2.kind;

endmodule
